>>> rtl/isc_pkg.sv
// Package for the insertion sorter: sizes, counter limits and sequencer states.
package isc_pkg;

    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed result field widths
    localparam int POS_W = 6;
    localparam int CNT_W = 11;
    localparam int REM_W = 6;
    localparam int TOT_W = 13;

    localparam logic [CNT_W-1:0] SHIFT_MAX = 11'd2047;
    localparam logic [TOT_W-1:0] TOTAL_MAX = 13'd8191;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CMP,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_EMIT_WAIT
    } t_state;

endpackage

>>> rtl/isc_store.sv
// Sorted value store: one write port, one registered read port.
module isc_store #(
    parameter int MAX_ITEMS  = isc_pkg::DEF_MAX_ITEMS,
    parameter int DATA_WIDTH = isc_pkg::DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(MAX_ITEMS)-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0]        i_wdata,
    input  logic [$clog2(MAX_ITEMS)-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0]        o_rdata
);
    import isc_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/insertion_sorter_with_counts_unit.sv
// Insertion sorter top level: sequencer, counters and result register.
//
//  channel  | dir | tdata fields (low bit up)                       | tlast
//  s_axis   | in  | value                                           | last_in
//  m_axis   | out | sorted_value, position, counters, overflow      | last_out
//
// An item shifts the larger entries up one per cycle through the store's one write port and
// the single comparator, then writes its key into the freed entry; an item that arrives
// with the store full is dropped. On last_in the store is read out one result at a time,
// each result held on m_axis until it is taken;
// s_axis is not ready until the last result is taken and the counters clear.
// i_rst_n is synchronous, active low; store contents are not cleared.
module insertion_sorter_with_counts_unit #(
    parameter int MAX_ITEMS  = isc_pkg::DEF_MAX_ITEMS,
    parameter int DATA_WIDTH = isc_pkg::DEF_DATA_WIDTH,
    localparam int IN_W  = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W =
        ((DATA_WIDTH + isc_pkg::POS_W + 2 * isc_pkg::CNT_W + 2 * isc_pkg::REM_W
          + isc_pkg::TOT_W + 1 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // value
    input  logic             i_s_axis_tlast,   // last_in
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // sorted_value, position, compare_count, swap_count, removal_count,
    // insertion_count, total_count, overflow, zero fill
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast    // last_out
);
    import isc_pkg::*;

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = ((CNT_W > CW) ? CNT_W : CW) + 2;
    localparam int PAY_W = DATA_WIDTH + POS_W + 2 * CNT_W + 2 * REM_W + TOT_W + 1;

    t_state r_state, n_state;

    logic [DATA_WIDTH-1:0] r_key;
    logic                  r_last;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_j;
    logic [AW-1:0]         r_k;
    logic [CNT_W-1:0]      r_shift;
    logic                  r_dropped;

    logic                  r_out_valid;
    logic [PAY_W-1:0]      r_out_data;
    logic                  r_out_last;

    // store port control
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic                  in_acc;
    logic                  out_acc;
    logic                  full;
    logic                  gt;
    logic                  k_is_last;
    logic [CW-1:0]         rem;
    logic [SUM_W-1:0]      sum;
    logic [TOT_W-1:0]      total;

    isc_store #(
        .MAX_ITEMS (MAX_ITEMS),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc   = r_out_valid && i_m_axis_tready;
    assign full      = (r_count == CW'(MAX_ITEMS));
    assign gt        = $signed(mem_rdata) > $signed(r_key);
    assign rem       = r_count - CW'(1);
    assign k_is_last = (CW'(r_k) == rem);
    assign sum       = SUM_W'({r_shift, 1'b0}) + SUM_W'({rem, 1'b0});
    assign total     = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (full) begin
                    n_state = r_last ? S_EMIT_RD : S_IDLE;
                end else if (r_count == '0) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!gt || r_j == AW'(1)) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                n_state = r_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                n_state = (r_count == '0) ? S_IDLE : S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (out_acc) begin
                    n_state = k_is_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // store port and handshake outputs
    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = r_j;
        mem_wdata       = r_key;
        mem_raddr       = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state) inside
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            S_START: begin
                mem_raddr = AW'(rem);
            end
            S_CMP: begin
                // shift larger entry up and fetch the next one down
                if (gt) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    mem_raddr = r_j - AW'(2);
                end
            end
            S_PLACE: begin
                mem_we = 1'b1;
            end
            S_EMIT_RD, S_EMIT_LOAD, S_EMIT_WAIT: begin
                mem_raddr = r_k;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key  <= i_s_axis_tdata[DATA_WIDTH-1:0];
            r_last <= i_s_axis_tlast;
        end
        if (r_state == S_START) begin
            r_j <= AW'(r_count);
        end else if (r_state == S_CMP && gt) begin
            r_j <= r_j - AW'(1);
        end
        if (r_state == S_EMIT_LOAD) begin
            r_out_data <= {r_dropped, total, REM_W'(rem), REM_W'(rem), r_shift, r_shift,
                           POS_W'(r_k), mem_rdata};
            r_out_last <= k_is_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_shift     <= '0;
            r_dropped   <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_START && full) begin
                r_dropped <= 1'b1;
            end
            if (r_state == S_CMP && gt && r_shift != SHIFT_MAX) begin
                r_shift <= r_shift + CNT_W'(1);
            end
            if (r_state == S_PLACE) begin
                r_count <= r_count + CW'(1);
                r_k     <= '0;
            end
            if (r_state == S_START && full) begin
                r_k <= '0;
            end
            if (r_state == S_EMIT_RD && r_count == '0) begin
                r_shift   <= '0;
                r_dropped <= 1'b0;
            end
            if (r_state == S_EMIT_LOAD) begin
                r_out_valid <= 1'b1;
            end
            if (r_state == S_EMIT_WAIT && out_acc) begin
                r_out_valid <= 1'b0;
                if (k_is_last) begin
                    r_count   <= '0;
                    r_shift   <= '0;
                    r_dropped <= 1'b0;
                end else begin
                    r_k <= r_k + AW'(1);
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);
    assign o_m_axis_tlast  = r_out_last;

endmodule
